// ===== hdl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants of the stuffed packet receiver
// Holds the payload buffer size, register indexes, error codes, parse phases
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spr_pkg;

    // Payload buffer depth and the field widths that follow from it
    localparam int PAYLOAD_DEPTH = 32;
    localparam int IDX_W         = 5;
    localparam int LEN_W         = 6;
    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int ERR_W         = 3;

    // Control bytes that are never valid on the link
    localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_CODE          = 3'd0,
        REG_ESCAPE_CODE         = 3'd1,
        REG_ESCAPED_START_CODE  = 3'd2,
        REG_ESCAPED_ESCAPE_CODE = 3'd3,
        REG_ESCAPED_ZERO_CODE   = 3'd4,
        REG_ESCAPED_ONES_CODE   = 3'd5
    } reg_index_t;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] RST_START_CODE          = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE         = 8'd125;
    localparam logic [BYTE_W-1:0] RST_ESCAPED_START_CODE  = 8'd94;
    localparam logic [BYTE_W-1:0] RST_ESCAPED_ESCAPE_CODE = 8'd93;
    localparam logic [BYTE_W-1:0] RST_ESCAPED_ZERO_CODE   = 8'd32;
    localparam logic [BYTE_W-1:0] RST_ESCAPED_ONES_CODE   = 8'd33;

    // Error report codes
    typedef enum logic [ERR_W-1:0] {
        ERR_IGNORED      = 3'd0,
        ERR_START_IN_PKT = 3'd1,
        ERR_OUTSIDE_PKT  = 3'd2,
        ERR_LEN_TOO_LONG = 3'd3,
        ERR_CHECKSUM     = 3'd4
    } err_code_t;

    // Result kinds
    localparam logic KIND_ERROR  = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    // Frame parse phase
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_ADDR = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_SUM  = 5'b10000
    } phase_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // take the offered link byte
        logic step;      // run the parser on the held byte
        logic load_err;  // load an error report into the output register
        logic load_pkt;  // load a packet byte into the output register
        logic rd_start;  // rewind the readout index
        logic rd_next;   // advance the readout index
    } spr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic err_valid; // the held byte raises an error report
        logic deliver;   // the held byte closes a good frame
        logic run_last;  // readout index sits on the final result
    } spr_status_t;

endpackage

// ===== hdl/spr_ram.sv =====
// ----------------------------------------------------------------------------
// spr_ram: generic single write port RAM with registered read
// One write and one read per cycle; read data is registered and appears in the cycle after its address.
// ----------------------------------------------------------------------------
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/spr_dpath.sv =====
// ----------------------------------------------------------------------------
// spr_dpath: parser datapath of the stuffed packet receiver
// Holds the configuration, the frame state, the payload buffer and the
// output register; parses one held byte per step command.
// ----------------------------------------------------------------------------
module spr_dpath
    import spr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  spr_cmd_t             cmd,
    output spr_status_t          status,
    output logic                 kind,
    output logic [ERR_W-1:0]     error_code,
    output logic [BYTE_W-1:0]    packet_address,
    output logic [LEN_W-1:0]     packet_length,
    output logic [IDX_W-1:0]     byte_index,
    output logic [BYTE_W-1:0]    payload_byte,
    output logic                 last
);

    // Configuration registers
    logic [BYTE_W-1:0] start_code_reg;
    logic [BYTE_W-1:0] escape_code_reg;
    logic [BYTE_W-1:0] esc_start_reg;
    logic [BYTE_W-1:0] esc_escape_reg;
    logic [BYTE_W-1:0] esc_zero_reg;
    logic [BYTE_W-1:0] esc_ones_reg;

    // Frame state
    phase_t            phase_reg, phase_next;
    logic              esc_pend_reg, esc_pend_next;
    logic [BYTE_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;

    // Held byte and readout index
    logic [BYTE_W-1:0] byte_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    // Output register
    logic              kind_reg;
    logic [ERR_W-1:0]  err_reg;
    logic [BYTE_W-1:0] oaddr_reg;
    logic [LEN_W-1:0]  olen_reg;
    logic [IDX_W-1:0]  oidx_reg;
    logic [BYTE_W-1:0] odata_reg;
    logic              olast_reg;

    // Parser results
    logic              err_valid;
    err_code_t         err_code;
    logic              deliver;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] dt;
    logic [LEN_W-1:0]  rem_dec;
    logic [LEN_W-1:0]  rd_idx_inc;
    logic              run_last;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg  <= RST_START_CODE;
            escape_code_reg <= RST_ESCAPE_CODE;
            esc_start_reg   <= RST_ESCAPED_START_CODE;
            esc_escape_reg  <= RST_ESCAPED_ESCAPE_CODE;
            esc_zero_reg    <= RST_ESCAPED_ZERO_CODE;
            esc_ones_reg    <= RST_ESCAPED_ONES_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_CODE:          start_code_reg  <= cfg_data;
                REG_ESCAPE_CODE:         escape_code_reg <= cfg_data;
                REG_ESCAPED_START_CODE:  esc_start_reg   <= cfg_data;
                REG_ESCAPED_ESCAPE_CODE: esc_escape_reg  <= cfg_data;
                REG_ESCAPED_ZERO_CODE:   esc_zero_reg    <= cfg_data;
                REG_ESCAPED_ONES_CODE:   esc_ones_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Translate an escaped byte back into its control byte
    always_comb
    begin
        dt = byte_reg;
        if (esc_pend_reg)
        begin
            priority if (byte_reg == esc_escape_reg)
                dt = escape_code_reg;
            else if (byte_reg == esc_start_reg)
                dt = start_code_reg;
            else if (byte_reg == esc_zero_reg)
                dt = BYTE_ZEROS;
            else if (byte_reg == esc_ones_reg)
                dt = BYTE_ONES;
            else
                dt = byte_reg;
        end
    end

    assign rem_dec = (rem_reg != '0) ? rem_reg - LEN_W'(1) : rem_reg;

    // Parse the held byte
    always_comb
    begin
        phase_next    = phase_reg;
        esc_pend_next = esc_pend_reg;
        addr_next     = addr_reg;
        rem_next      = rem_reg;
        sum_next      = sum_reg;
        fill_next     = fill_reg;
        err_valid     = 1'b0;
        err_code      = ERR_IGNORED;
        deliver       = 1'b0;
        ram_we        = 1'b0;
        ram_wdata     = dt;
        if (cmd.step)
        begin
            priority if (byte_reg == BYTE_ZEROS || byte_reg == BYTE_ONES)
            begin
                // Drop bytes that never appear on the link
                err_valid = 1'b1;
                err_code  = ERR_IGNORED;
            end
            else if (byte_reg == start_code_reg)
            begin
                // Open a new frame, flagging one that was still open
                if (phase_reg != PH_IDLE)
                begin
                    err_valid = 1'b1;
                    err_code  = ERR_START_IN_PKT;
                end
                phase_next    = PH_ADDR;
                fill_next     = '0;
                esc_pend_next = 1'b0;
            end
            else if (phase_reg == PH_IDLE)
            begin
                err_valid = 1'b1;
                err_code  = ERR_OUTSIDE_PKT;
            end
            else if (byte_reg == escape_code_reg)
            begin
                esc_pend_next = 1'b1;
            end
            else
            begin
                esc_pend_next = 1'b0;
                unique case (phase_reg)
                    PH_ADDR:
                    begin
                        addr_next  = dt;
                        sum_next   = dt;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (dt > BYTE_W'(PAYLOAD_DEPTH))
                        begin
                            phase_next = PH_IDLE;
                            err_valid  = 1'b1;
                            err_code   = ERR_LEN_TOO_LONG;
                        end
                        else
                        begin
                            rem_next   = dt[LEN_W-1:0];
                            sum_next   = sum_reg + dt;
                            phase_next = (dt == '0) ? PH_SUM : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (fill_reg < LEN_W'(PAYLOAD_DEPTH))
                        begin
                            ram_we    = 1'b1;
                            fill_next = fill_reg + LEN_W'(1);
                        end
                        sum_next = sum_reg + dt;
                        rem_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        phase_next = PH_IDLE;
                        if (dt != ~sum_reg)
                        begin
                            err_valid = 1'b1;
                            err_code  = ERR_CHECKSUM;
                        end
                        else
                        begin
                            deliver = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Update frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            esc_pend_reg <= 1'b0;
            addr_reg     <= '0;
            rem_reg      <= '0;
            sum_reg      <= '0;
            fill_reg     <= '0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            esc_pend_reg <= esc_pend_next;
            addr_reg     <= addr_next;
            rem_reg      <= rem_next;
            sum_reg      <= sum_next;
            fill_reg     <= fill_next;
            if (cmd.rd_start)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_next)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
        end
    end

    // Hold the accepted link byte
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Payload buffer
    spr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Final result of a run: the only one of an empty packet, else the top index
    assign rd_idx_inc = {1'b0, rd_idx_reg} + LEN_W'(1);
    assign run_last   = (fill_reg == '0) || (rd_idx_inc == fill_reg);

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            kind_reg  <= KIND_ERROR;
            err_reg   <= err_code;
            oaddr_reg <= '0;
            olen_reg  <= '0;
            oidx_reg  <= '0;
            odata_reg <= '0;
            olast_reg <= 1'b1;
        end
        else if (cmd.load_pkt)
        begin
            kind_reg  <= KIND_PACKET;
            err_reg   <= '0;  // no error code on packet bytes
            oaddr_reg <= addr_reg;
            olen_reg  <= fill_reg;
            oidx_reg  <= (fill_reg == '0) ? '0 : rd_idx_reg;
            odata_reg <= (fill_reg == '0) ? '0 : ram_rdata;
            olast_reg <= run_last;
        end
    end

    assign status.err_valid = err_valid;
    assign status.deliver   = deliver;
    assign status.run_last  = run_last;

    assign kind           = kind_reg;
    assign error_code     = err_reg;
    assign packet_address = oaddr_reg;
    assign packet_length  = olen_reg;
    assign byte_index     = oidx_reg;
    assign payload_byte   = odata_reg;
    assign last           = olast_reg;

endmodule

// ===== hdl/spr_ctrl.sv =====
// ----------------------------------------------------------------------------
// spr_ctrl: sequencing controller of the stuffed packet receiver
// Takes a beat, runs the parser on it, and plays a good packet out of the
// payload buffer one result at a time; owns the output valid flag.
// ----------------------------------------------------------------------------
module spr_ctrl
    import spr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  spr_status_t status,
    output spr_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_ACCEPT = 4'b0001,
        S_EXEC   = 4'b0010,
        S_READ   = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   slot_free;

    // Output register can take a new result this cycle
    assign slot_free = !ovalid_reg || out_ready;

    // Sequence the work on one beat
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_ACCEPT:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Hold until a possible error report has a place to go
                if (slot_free)
                begin
                    cmd.step     = 1'b1;
                    cmd.load_err = status.err_valid;
                    if (status.deliver)
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = S_READ;
                    end
                    else
                    begin
                        state_next = S_ACCEPT;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.load_pkt = 1'b1;
                    if (status.run_last)
                    begin
                        state_next = S_ACCEPT;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase
    end

    // Track the output register occupancy
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.load_err || cmd.load_pkt)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_ACCEPT;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_ACCEPT);
    assign out_valid = ovalid_reg;

endmodule

// ===== hdl/stuffed_packet_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// stuffed_packet_receiver_unit: byte-stuffed packet deframer
// Input channel in_valid/in_ready/rx_byte carries one raw link byte per beat.
// Output channel out_valid/out_ready carries results: error reports (one
// beat each, last set) and delivered packets (one beat per payload byte, or
// one zero beat for an empty packet, last set on the final beat).
// Frames: start byte, address, length, payload, inverted 8-bit sum of
// address, length and payload. Escaped bytes are translated back.
// An error report is loaded when its beat is parsed, after the capture step;
// the first beat of a delivered packet follows its checksum beat through the
// read and emit states. A new beat is taken only once the capture and parse
// steps of the last one are done, and each payload byte of a delivered
// packet passes the registered payload buffer read before it is emitted.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle and is meant for idle periods.
// Reset clears the frame state and loads the default control codes; the
// payload buffer keeps no reset value. While the receiver stalls, the output
// register holds its beat and the unit stops taking input once the next
// result has nowhere to go.
// ----------------------------------------------------------------------------
module stuffed_packet_receiver_unit
    import spr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 kind,
    output logic [ERR_W-1:0]     error_code,
    output logic [BYTE_W-1:0]    packet_address,
    output logic [LEN_W-1:0]     packet_length,
    output logic [IDX_W-1:0]     byte_index,
    output logic [BYTE_W-1:0]    payload_byte,
    output logic                 last
);

    spr_cmd_t    cmd;
    spr_status_t status;

    // Sequencing controller
    spr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Parser datapath
    spr_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .error_code     (error_code),
        .packet_address (packet_address),
        .packet_length  (packet_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .last           (last)
    );

endmodule

// ===== verif/tb_stuffed_packet_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// tb_stuffed_packet_receiver_unit: self-checking bench of the packet deframer
// Feeds link bytes through a valid/ready driver and checks every result beat
// against an in-bench deframer model, in order and field by field. A short
// directed opening is followed by random byte-stuffed traffic: mostly clean
// frames, plus bad checksums, oversized lengths, cut frames and line noise.
// The run walks through several control-code settings, including extreme
// and shared escape codes, under varied sender gaps and receiver stalls,
// with one long receiver hold-off that backs the unit up into its input.
// ----------------------------------------------------------------------------
module tb_stuffed_packet_receiver_unit;
    import spr_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 16;

    // One expected or observed result beat
    typedef struct packed {
        logic              kind;
        logic [ERR_W-1:0]  code;
        logic [BYTE_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
        logic              last;
    } deframed_beat_t;

    // Ways a generated frame can be damaged
    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_CUT,
        FLAW_LONG
    } frame_flaw_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 kind;
    logic [ERR_W-1:0]     error_code;
    logic [BYTE_W-1:0]    packet_address;
    logic [LEN_W-1:0]     packet_length;
    logic [IDX_W-1:0]     byte_index;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 last;

    // Link bytes waiting to be offered and results still owed by the unit
    logic [BYTE_W-1:0] link_bytes [$];
    deframed_beat_t    awaited_beats [$];
    int                bytes_in_flight = 0;
    int                queued_total = 0;
    int                mismatch_count = 0;

    // Idling controls and the long receiver hold-off
    int   sender_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_kick = 1'b0;
    int   hold_cnt = 0;

    // Control codes as currently programmed, indexed by register
    logic [BYTE_W-1:0] link_codes [0:5];

    // Deframer model state
    phase_t            parse_phase = PH_IDLE;
    logic              escape_armed = 1'b0;
    logic [BYTE_W-1:0] frame_addr = '0;
    int                bytes_left = 0;
    logic [BYTE_W-1:0] frame_sum = '0;
    int                stored_count = 0;
    logic [BYTE_W-1:0] payload_copy [0:PAYLOAD_DEPTH-1];

    stuffed_packet_receiver_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .error_code     (error_code),
        .packet_address (packet_address),
        .packet_length  (packet_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .last           (last)
    );

    always #10 clk = ~clk;

    function automatic deframed_beat_t error_beat(input logic [ERR_W-1:0] code);
        deframed_beat_t b;
        b = '0;
        b.kind = KIND_ERROR;
        b.code = code;
        b.last = 1'b1;
        return b;
    endfunction

    // Advance the deframer model by one accepted link byte
    task automatic predict_link_byte(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] d;
        deframed_beat_t    b;
        int                i;
        d = raw;
        if (raw == BYTE_ZEROS || raw == BYTE_ONES)
        begin
            awaited_beats.push_back(error_beat(ERR_IGNORED));
            return;
        end
        if (raw == link_codes[REG_START_CODE])
        begin
            if (parse_phase != PH_IDLE)
                awaited_beats.push_back(error_beat(ERR_START_IN_PKT));
            parse_phase = PH_ADDR;
            stored_count = 0;
            escape_armed = 1'b0;
            return;
        end
        if (parse_phase == PH_IDLE)
        begin
            awaited_beats.push_back(error_beat(ERR_OUTSIDE_PKT));
            return;
        end
        if (raw == link_codes[REG_ESCAPE_CODE])
        begin
            escape_armed = 1'b1;
            return;
        end
        // Undo the stuffing; escape wins over start, zero and ones
        if (escape_armed)
        begin
            escape_armed = 1'b0;
            if (raw == link_codes[REG_ESCAPED_ESCAPE_CODE])
                d = link_codes[REG_ESCAPE_CODE];
            else if (raw == link_codes[REG_ESCAPED_START_CODE])
                d = link_codes[REG_START_CODE];
            else if (raw == link_codes[REG_ESCAPED_ZERO_CODE])
                d = BYTE_ZEROS;
            else if (raw == link_codes[REG_ESCAPED_ONES_CODE])
                d = BYTE_ONES;
        end
        case (parse_phase)
            PH_ADDR:
            begin
                frame_addr = d;
                frame_sum = d;
                parse_phase = PH_LEN;
            end
            PH_LEN:
            begin
                if (d > PAYLOAD_DEPTH)
                begin
                    parse_phase = PH_IDLE;
                    awaited_beats.push_back(error_beat(ERR_LEN_TOO_LONG));
                end
                else
                begin
                    bytes_left = d;
                    frame_sum = frame_sum + d;
                    parse_phase = (d == 0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (stored_count < PAYLOAD_DEPTH)
                begin
                    payload_copy[stored_count] = d;
                    stored_count++;
                end
                frame_sum = frame_sum + d;
                if (bytes_left > 0)
                    bytes_left--;
                if (bytes_left == 0)
                    parse_phase = PH_SUM;
            end
            PH_SUM:
            begin
                parse_phase = PH_IDLE;
                if (d != ~frame_sum)
                    awaited_beats.push_back(error_beat(ERR_CHECKSUM));
                else
                begin
                    // Deliver the buffered packet, one zero beat if empty
                    b = '0;
                    b.kind = KIND_PACKET;
                    b.code = ERR_IGNORED;
                    b.addr = frame_addr;
                    b.len = LEN_W'(stored_count);
                    if (stored_count == 0)
                    begin
                        b.last = 1'b1;
                        awaited_beats.push_back(b);
                    end
                    for (i = 0; i < stored_count; i++)
                    begin
                        b.idx = IDX_W'(i);
                        b.data = payload_copy[i];
                        b.last = (i + 1 == stored_count);
                        awaited_beats.push_back(b);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Compare one result beat against the oldest expectation
    task automatic check_result_beat();
        deframed_beat_t want;
        if (awaited_beats.size() == 0)
        begin
            $display("%0t: unexpected beat, expected none, got kind %0d code %0d",
                     $time, kind, error_code);
            mismatch_count++;
            return;
        end
        want = awaited_beats.pop_front();
        check_field("kind", want.kind, kind);
        check_field("error_code", want.code, error_code);
        check_field("packet_address", want.addr, packet_address);
        check_field("packet_length", want.len, packet_length);
        check_field("byte_index", want.idx, byte_index);
        check_field("payload_byte", want.data, payload_byte);
        check_field("last", want.last, last);
    endtask

    // Driver: offer queued link bytes, hold each until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_link_byte(rx_byte);
                bytes_in_flight--;
            end
            if (!in_valid || in_ready)
            begin
                if (link_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= link_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result beat, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                check_result_beat();
            out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // Count down the long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_kick)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    task automatic queue_raw(input logic [BYTE_W-1:0] b);
        link_bytes.push_back(b);
        bytes_in_flight++;
        queued_total++;
    endtask

    // Stuff a frame byte; now and then slip a dropped byte in front of it
    task automatic queue_stuffed(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < 3)
            queue_raw($urandom_range(1) ? BYTE_ONES : BYTE_ZEROS);
        if (b == link_codes[REG_START_CODE])
        begin
            queue_raw(link_codes[REG_ESCAPE_CODE]);
            queue_raw(link_codes[REG_ESCAPED_START_CODE]);
        end
        else if (b == link_codes[REG_ESCAPE_CODE])
        begin
            queue_raw(link_codes[REG_ESCAPE_CODE]);
            queue_raw(link_codes[REG_ESCAPED_ESCAPE_CODE]);
        end
        else if (b == BYTE_ZEROS)
        begin
            queue_raw(link_codes[REG_ESCAPE_CODE]);
            queue_raw(link_codes[REG_ESCAPED_ZERO_CODE]);
        end
        else if (b == BYTE_ONES)
        begin
            queue_raw(link_codes[REG_ESCAPE_CODE]);
            queue_raw(link_codes[REG_ESCAPED_ONES_CODE]);
        end
        else
            queue_raw(b);
    endtask

    // Payload byte, biased toward values that need stuffing
    function automatic logic [BYTE_W-1:0] pick_payload_byte();
        case ($urandom_range(11))
            0: return link_codes[REG_START_CODE];
            1: return link_codes[REG_ESCAPE_CODE];
            2: return BYTE_ZEROS;
            3: return BYTE_ONES;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // Mostly short payloads, some empty and some full
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 0;
        if (roll < 20)
            return PAYLOAD_DEPTH;
        if (roll < 30)
            return $urandom_range(PAYLOAD_DEPTH - 1, 9);
        return $urandom_range(8, 1);
    endfunction

    task automatic queue_frame(input logic [BYTE_W-1:0] addr, input int len,
                               input frame_flaw_t flaw);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] d;
        int                cut;
        int                i;
        queue_raw(link_codes[REG_START_CODE]);
        queue_stuffed(addr);
        if (flaw == FLAW_LONG)
        begin
            queue_stuffed(BYTE_W'($urandom_range(255, PAYLOAD_DEPTH + 1)));
            return;
        end
        queue_stuffed(BYTE_W'(len));
        sum = addr + BYTE_W'(len);
        cut = (flaw == FLAW_CUT) ? $urandom_range(len - 1) : len;
        for (i = 0; i < cut; i++)
        begin
            d = pick_payload_byte();
            sum = sum + d;
            queue_stuffed(d);
        end
        // Cut frames stop short and leave the next start to hit an open frame
        if (flaw == FLAW_CUT)
            return;
        if (flaw == FLAW_SUM)
            queue_stuffed(~sum ^ (8'h01 << $urandom_range(7)));
        else
            queue_stuffed(~sum);
    endtask

    task automatic queue_random_traffic(input int budget);
        int stop_at;
        int pick;
        int n;
        int k;
        stop_at = queued_total + budget;
        while (queued_total < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 68)
                queue_frame(BYTE_W'($urandom_range(255)), pick_length(), FLAW_NONE);
            else if (pick < 76)
                queue_frame(BYTE_W'($urandom_range(255)), pick_length(), FLAW_SUM);
            else if (pick < 82)
                queue_frame(BYTE_W'($urandom_range(255)), 0, FLAW_LONG);
            else if (pick < 88)
                queue_frame(BYTE_W'($urandom_range(255)), $urandom_range(8, 1), FLAW_CUT);
            else
            begin
                n = $urandom_range(3, 1);
                for (k = 0; k < n; k++)
                    queue_raw(BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    // Wait until every byte is taken and every result has come back
    task automatic settle();
        while (bytes_in_flight != 0 || awaited_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_code(input reg_index_t idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        link_codes[idx] = val;
    endtask

    task automatic program_codes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                                 input logic [BYTE_W-1:0] es, input logic [BYTE_W-1:0] ee,
                                 input logic [BYTE_W-1:0] ez, input logic [BYTE_W-1:0] eo);
        write_code(REG_START_CODE, s);
        write_code(REG_ESCAPE_CODE, e);
        write_code(REG_ESCAPED_START_CODE, es);
        write_code(REG_ESCAPED_ESCAPE_CODE, ee);
        write_code(REG_ESCAPED_ZERO_CODE, ez);
        write_code(REG_ESCAPED_ONES_CODE, eo);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int idle, input int stall, input int budget);
        sender_idle_pct <= idle;
        stall_pct <= stall;
        queue_random_traffic(budget);
        settle();
    endtask

    // Stimulus sequence
    initial
    begin
        link_codes[REG_START_CODE] = RST_START_CODE;
        link_codes[REG_ESCAPE_CODE] = RST_ESCAPE_CODE;
        link_codes[REG_ESCAPED_START_CODE] = RST_ESCAPED_START_CODE;
        link_codes[REG_ESCAPED_ESCAPE_CODE] = RST_ESCAPED_ESCAPE_CODE;
        link_codes[REG_ESCAPED_ZERO_CODE] = RST_ESCAPED_ZERO_CODE;
        link_codes[REG_ESCAPED_ONES_CODE] = RST_ESCAPED_ONES_CODE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Dropped bytes and stray bytes before any frame, escape included
        queue_raw(BYTE_ZEROS);
        queue_raw(BYTE_ONES);
        queue_raw(8'h41);
        queue_raw(RST_ESCAPE_CODE);
        // Empty frame, address 0xFF, every field escaped
        queue_raw(RST_START_CODE);
        queue_raw(RST_ESCAPE_CODE);
        queue_raw(RST_ESCAPED_ONES_CODE);
        queue_raw(RST_ESCAPE_CODE);
        queue_raw(RST_ESCAPED_ZERO_CODE);
        queue_raw(RST_ESCAPE_CODE);
        queue_raw(RST_ESCAPED_ZERO_CODE);
        // Start inside a frame, double escape, unknown escaped length too long
        queue_raw(RST_START_CODE);
        queue_raw(RST_START_CODE);
        queue_raw(RST_ESCAPE_CODE);
        queue_raw(RST_ESCAPE_CODE);
        queue_raw(RST_ESCAPED_ESCAPE_CODE);
        queue_raw(RST_ESCAPE_CODE);
        queue_raw(8'h41);
        // Dropped byte after an escape keeps it pending; then a bad checksum
        queue_raw(RST_START_CODE);
        queue_raw(8'h10);
        queue_raw(8'h02);
        queue_raw(8'hAB);
        queue_raw(RST_ESCAPE_CODE);
        queue_raw(BYTE_ZEROS);
        queue_raw(RST_ESCAPED_START_CODE);
        queue_raw(8'h55);
        settle();

        // Back-to-back traffic with a long receiver hold-off
        sender_idle_pct <= 0;
        stall_pct <= 0;
        queue_random_traffic(90);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        settle();

        program_codes(8'h01, 8'hFE, 8'h11, 8'h22, 8'h33, 8'h44);
        run_phase(69, 0, 80);
        program_codes(8'hC0, 8'hDB, 8'hDC, 8'hDD, 8'h9A, 8'h9B);
        run_phase(0, 69, 80);
        // All escaped codes shared: escape translation takes precedence
        program_codes(8'h7E, 8'h7D, 8'h5A, 8'h5A, 8'h5A, 8'h5A);
        run_phase(22, 22, 40);
        // Extreme codes: no frame can ever open
        program_codes(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
        run_phase(22, 22, 15);
        program_codes(RST_START_CODE, RST_ESCAPE_CODE, RST_ESCAPED_START_CODE,
                      RST_ESCAPED_ESCAPE_CODE, RST_ESCAPED_ZERO_CODE,
                      RST_ESCAPED_ONES_CODE);
        run_phase(22, 22, 30);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/spr_pkg.sv
hdl/spr_ram.sv
hdl/spr_dpath.sv
hdl/spr_ctrl.sv
hdl/stuffed_packet_receiver_unit.sv
verif/tb_stuffed_packet_receiver_unit.sv
